// ===== hw/rtl/dmscs_pkg.sv =====
// Package for the dial mask scale/center scanner.
// Field widths, register indexes and reset constants; no dependencies.
`timescale 1ns / 1ps

package dmscs_pkg;

    localparam int COORD_W   = 12;   // width of every output coordinate
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;   // widest configuration register
    localparam int CFG_IDX_W = 1;

    localparam int MAX_COLS_DEF = 4096;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    localparam logic [PIX_W-1:0] SCALE_MARK = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

endpackage

// ===== hw/rtl/dial_mask_scale_center_scan.sv =====
// Dial mask scale/center scanner: counts raster position and tracks scale
// endpoints and the widest nonzero span. Depends on dmscs_pkg.
// The result is in the output register in the cycle after the frame's
// last pixel request is accepted.
// Throughput: one pixel per cycle; all per-pixel work is one state update.
//   Input stalls only when a finished result is still waiting and the next
//   pixel would close another frame.
// Reset: frame_width 640, frame_height 480, scan state set to the start of a frame, no result.
`timescale 1ns / 1ps

module dial_mask_scale_center_scan #(
    parameter int MAX_COLS = dmscs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = dmscs_pkg::MAX_ROWS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [dmscs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmscs_pkg::CFG_W-1:0]           cfg_data,
    // pixel channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [dmscs_pkg::PIX_W-1:0]           pixel,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [dmscs_pkg::COORD_W-1:0]         begin_x,
    output logic [dmscs_pkg::COORD_W-1:0]         begin_y,
    output logic [dmscs_pkg::COORD_W-1:0]         end_x,
    output logic [dmscs_pkg::COORD_W-1:0]         end_y,
    output logic                                  scale_ok,
    output logic [dmscs_pkg::COORD_W-1:0]         center_x,
    output logic [dmscs_pkg::COORD_W-1:0]         center_y,
    output logic                                  center_ok
);

    // column / row counter widths
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // coordinate math widths: at least the output width, so the final
    // truncation to 12 bits always has bits to select
    localparam int XW = (CW > dmscs_pkg::COORD_W) ? CW : dmscs_pkg::COORD_W;
    localparam int YW = (RW > dmscs_pkg::COORD_W) ? RW : dmscs_pkg::COORD_W;

    // reset geometry, clipped to the parameter range
    localparam int W_RST = (dmscs_pkg::WIDTH_RST > MAX_COLS) ? MAX_COLS
                                                             : dmscs_pkg::WIDTH_RST;
    localparam int H_RST = (dmscs_pkg::HEIGHT_RST > MAX_ROWS) ? MAX_ROWS
                                                              : dmscs_pkg::HEIGHT_RST;
    localparam logic [CW-1:0] LAST_COL_RST = CW'(W_RST - 1);
    localparam logic [CW-1:0] HALF_RST     = CW'(W_RST / 2);
    localparam logic [RW-1:0] LAST_ROW_RST = RW'(H_RST - 1);

    // ---------------------------------------------------------------
    // Geometry registers: stored pre-decoded as last column, half
    // width and last row index so the per-pixel path only compares.
    // ---------------------------------------------------------------
    logic [CW-1:0] last_col_reg, last_col_next;
    logic [CW-1:0] half_reg,     half_next;
    logic [RW-1:0] last_row_reg, last_row_next;

    logic [31:0]   cfg_val;
    logic [31:0]   w_sat;
    logic [31:0]   h_sat;
    logic [31:0]   w_dec;
    logic [31:0]   h_dec;

    always_comb
    begin
        cfg_val = {{(32 - dmscs_pkg::CFG_W){1'b0}}, cfg_data};
        // saturate width to [2, MAX_COLS], height to [1, MAX_ROWS]
        if (cfg_val < 32'd2)
            w_sat = 32'd2;
        else if (cfg_val > 32'(MAX_COLS))
            w_sat = 32'(MAX_COLS);
        else
            w_sat = cfg_val;
        if (cfg_val < 32'd1)
            h_sat = 32'd1;
        else if (cfg_val > 32'(MAX_ROWS))
            h_sat = 32'(MAX_ROWS);
        else
            h_sat = cfg_val;
        w_dec = w_sat - 32'd1;
        h_dec = h_sat - 32'd1;

        last_col_next = last_col_reg;
        half_next     = half_reg;
        last_row_next = last_row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dmscs_pkg::REG_FRAME_WIDTH:
                begin
                    last_col_next = w_dec[CW-1:0];
                    half_next     = w_sat[CW:1];
                end
                dmscs_pkg::REG_FRAME_HEIGHT:
                begin
                    last_row_next = h_dec[RW-1:0];
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= LAST_COL_RST;
            half_reg     <= HALF_RST;
            last_row_reg <= LAST_ROW_RST;
        end
        else
        begin
            last_col_reg <= last_col_next;
            half_reg     <= half_next;
            last_row_reg <= last_row_next;
        end
    end

    // ---------------------------------------------------------------
    // Scan state
    // ---------------------------------------------------------------
    logic [CW-1:0] col_reg,        col_next;
    logic [RW-1:0] row_reg,        row_next;
    logic [CW-1:0] begin_col_reg,  begin_col_next;
    logic [RW-1:0] begin_row_reg,  begin_row_next;
    logic          begin_fnd_reg,  begin_fnd_next;
    logic [CW-1:0] end_col_reg,    end_col_next;
    logic [RW-1:0] end_row_reg,    end_row_next;
    logic          end_fnd_reg,    end_fnd_next;
    logic          frozen_reg,     frozen_next;
    logic [CW-1:0] row_first_reg,  row_first_next;
    logic [CW-1:0] row_last_reg,   row_last_next;
    logic          row_has_reg,    row_has_next;
    logic [CW-1:0] best_span_reg,  best_span_next;
    logic [RW-1:0] best_top_reg,   best_top_next;
    logic [RW-1:0] best_frst_reg,  best_frst_next;
    logic [CW-1:0] best_left_reg,  best_left_next;
    logic [CW-1:0] best_right_reg, best_right_next;

    logic          accept;
    logic          row_end;
    logic          frame_end;
    logic          restart;
    logic          nz;
    logic          mark;
    logic [CW-1:0] first_eff;
    logic [CW-1:0] last_eff;
    logic          has_eff;
    logic [CW-1:0] span;

    logic          out_valid_reg;

    // A pixel closing the frame would overwrite a result that is still
    // held; only then is the pixel request stalled.
    assign row_end   = (col_reg >= last_col_reg);
    assign frame_end = row_end && (row_reg == '0);
    assign in_stall  = out_valid_reg && out_stall && frame_end;
    assign accept    = in_valid && !in_stall;
    // new frame after the result or after any register write
    assign restart   = (accept && frame_end) || cfg_we;

    assign nz        = (pixel != '0);
    assign mark      = (pixel == dmscs_pkg::SCALE_MARK);
    // row span including the current pixel
    assign first_eff = row_has_reg ? row_first_reg : col_reg;
    assign last_eff  = nz ? col_reg : row_last_reg;
    assign has_eff   = row_has_reg || nz;
    assign span      = last_eff - first_eff;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        begin_col_next  = begin_col_reg;
        begin_row_next  = begin_row_reg;
        begin_fnd_next  = begin_fnd_reg;
        end_col_next    = end_col_reg;
        end_row_next    = end_row_reg;
        end_fnd_next    = end_fnd_reg;
        frozen_next     = frozen_reg;
        row_first_next  = row_first_reg;
        row_last_next   = row_last_reg;
        row_has_next    = row_has_reg;
        best_span_next  = best_span_reg;
        best_top_next   = best_top_reg;
        best_frst_next  = best_frst_reg;
        best_left_next  = best_left_reg;
        best_right_next = best_right_reg;

        if (accept)
        begin
            // scale endpoints: first 255 in each half, until frozen
            if (!frozen_reg && mark)
            begin
                if (col_reg < half_reg)
                begin
                    if (!begin_fnd_reg)
                    begin
                        begin_fnd_next = 1'b1;
                        begin_col_next = col_reg;
                        begin_row_next = row_reg;
                    end
                end
                else if (!end_fnd_reg)
                begin
                    end_fnd_next = 1'b1;
                    end_col_next = col_reg;
                    end_row_next = row_reg;
                end
            end

            if (nz)
            begin
                row_has_next  = 1'b1;
                row_first_next = first_eff;
                row_last_next  = col_reg;
            end

            if (!row_end)
            begin
                col_next = col_reg + 1'b1;
            end
            else
            begin
                if (begin_fnd_next && end_fnd_next)
                    frozen_next = 1'b1;
                // widest span; ties move the bottom-most row marker
                if (has_eff && (span != '0) && (span >= best_span_reg))
                begin
                    if (span > best_span_reg)
                        best_frst_next = row_reg;
                    best_top_next   = row_reg;
                    best_span_next  = span;
                    best_left_next  = first_eff;
                    best_right_next = last_eff;
                end
                row_has_next   = 1'b0;
                row_first_next = '0;
                row_last_next  = '0;
                col_next       = '0;
                row_next       = row_reg - 1'b1;
            end
        end
    end

    // the _next values stay pre-restart so the result can be built from them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= LAST_ROW_RST;
            begin_col_reg  <= '0;
            begin_row_reg  <= '0;
            begin_fnd_reg  <= 1'b0;
            end_col_reg    <= '0;
            end_row_reg    <= '0;
            end_fnd_reg    <= 1'b0;
            frozen_reg     <= 1'b0;
            row_first_reg  <= '0;
            row_last_reg   <= '0;
            row_has_reg    <= 1'b0;
            best_span_reg  <= '0;
            best_top_reg   <= '0;
            best_frst_reg  <= '0;
            best_left_reg  <= '0;
            best_right_reg <= '0;
        end
        else if (restart)
        begin
            col_reg        <= '0;
            row_reg        <= last_row_next;
            begin_col_reg  <= '0;
            begin_row_reg  <= '0;
            begin_fnd_reg  <= 1'b0;
            end_col_reg    <= '0;
            end_row_reg    <= '0;
            end_fnd_reg    <= 1'b0;
            frozen_reg     <= 1'b0;
            row_first_reg  <= '0;
            row_last_reg   <= '0;
            row_has_reg    <= 1'b0;
            best_span_reg  <= '0;
            best_top_reg   <= '0;
            best_frst_reg  <= '0;
            best_left_reg  <= '0;
            best_right_reg <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            begin_col_reg  <= begin_col_next;
            begin_row_reg  <= begin_row_next;
            begin_fnd_reg  <= begin_fnd_next;
            end_col_reg    <= end_col_next;
            end_row_reg    <= end_row_next;
            end_fnd_reg    <= end_fnd_next;
            frozen_reg     <= frozen_next;
            row_first_reg  <= row_first_next;
            row_last_reg   <= row_last_next;
            row_has_reg    <= row_has_next;
            best_span_reg  <= best_span_next;
            best_top_reg   <= best_top_next;
            best_frst_reg  <= best_frst_next;
            best_left_reg  <= best_left_next;
            best_right_reg <= best_right_next;
        end
    end

    // ---------------------------------------------------------------
    // Result: built from the updated (pre-restart) state on the
    // frame's last pixel. Midpoints are floor sums shifted by one.
    // ---------------------------------------------------------------
    logic          res_fire;
    logic          sok;
    logic          cok;
    logic [XW-1:0] bx_ext;
    logic [YW-1:0] by_ext;
    logic [XW-1:0] ex_ext;
    logic [YW-1:0] ey_ext;
    logic [XW:0]   cx_sum;
    logic [YW:0]   cy_sum;

    assign res_fire = accept && frame_end;
    assign sok      = begin_fnd_next && end_fnd_next;
    assign cok      = (best_span_next != '0);
    assign bx_ext   = XW'(begin_col_next);
    assign by_ext   = YW'(begin_row_next);
    assign ex_ext   = XW'(end_col_next);
    assign ey_ext   = YW'(end_row_next);
    assign cx_sum   = (XW + 1)'(best_left_next) + (XW + 1)'(best_right_next);
    assign cy_sum   = (YW + 1)'(best_top_next) + (YW + 1)'(best_frst_next);

    logic [dmscs_pkg::COORD_W-1:0] begin_x_reg, begin_y_reg, end_x_reg, end_y_reg;
    logic [dmscs_pkg::COORD_W-1:0] center_x_reg, center_y_reg;
    logic                          scale_ok_reg, center_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            begin_x_reg   <= sok ? bx_ext[dmscs_pkg::COORD_W-1:0] : '0;
            begin_y_reg   <= sok ? by_ext[dmscs_pkg::COORD_W-1:0] : '0;
            end_x_reg     <= sok ? ex_ext[dmscs_pkg::COORD_W-1:0] : '0;
            end_y_reg     <= sok ? ey_ext[dmscs_pkg::COORD_W-1:0] : '0;
            scale_ok_reg  <= sok;
            center_x_reg  <= cok ? cx_sum[dmscs_pkg::COORD_W:1] : '0;
            center_y_reg  <= cok ? cy_sum[dmscs_pkg::COORD_W:1] : '0;
            center_ok_reg <= cok;
        end
    end

    assign out_valid = out_valid_reg;
    assign begin_x   = begin_x_reg;
    assign begin_y   = begin_y_reg;
    assign end_x     = end_x_reg;
    assign end_y     = end_y_reg;
    assign scale_ok  = scale_ok_reg;
    assign center_x  = center_x_reg;
    assign center_y  = center_y_reg;
    assign center_ok = center_ok_reg;

endmodule
